FILE: rtl/bounded_ordered_list_macros.svh
// Assertion macros used by the checker file of the ordered list.
`ifndef BOUNDED_ORDERED_LIST_MACROS_SVH
`define BOUNDED_ORDERED_LIST_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BOL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BOL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

FILE: rtl/bol_pkg.sv
package bol_pkg;

    localparam int OP_W       = 3;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 6;
    localparam int CELL_IDX_W = 11;

    // Operation codes of an input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 3'd0,
        OP_APPEND      = 3'd1,
        OP_REMOVE      = 3'd2,
        OP_REMOVE_LAST = 3'd3,
        OP_READ        = 3'd4,
        OP_CLEAR       = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // One move record as held in a cell.
    typedef struct packed {
        logic [7:0] from_row;
        logic [7:0] from_col;
        logic [3:0] moved_piece;
        logic [7:0] to_row;
        logic [7:0] to_col;
        logic [3:0] taken_piece;
    } rec_t;

    // Shift commands broadcast to every cell.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             clr;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

    // Outcome of one operation, as loaded into the result register.
    typedef struct packed {
        status_t          status;
        logic             rd_ok;
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
    } res_info_t;

endpackage

FILE: rtl/bol_cell.sv
module bol_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bol_pkg::cell_ctrl_t ctrl,
    input  bol_pkg::rec_t     left,
    input  bol_pkg::rec_t     right,
    input  bol_pkg::rec_t     new_rec,
    output bol_pkg::rec_t     q
);
    import bol_pkg::*;

    localparam logic [CELL_IDX_W-1:0] IDX_V = CELL_IDX_W'(IDX);

    logic [CELL_IDX_W-1:0] pos_ext;
    rec_t                  data_reg;
    rec_t                  data_next;

    assign pos_ext = {{(CELL_IDX_W-POS_W){1'b0}}, ctrl.pos};

    // Zero on clear, new_rec or left on insert, right on remove, else hold.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.clr)
        begin
            data_next = '0;
        end
        else if (ctrl.ins && (IDX_V > pos_ext))
        begin
            data_next = left;
        end
        else if (ctrl.ins && (IDX_V == pos_ext))
        begin
            data_next = new_rec;
        end
        else if (ctrl.rem && (IDX_V >= pos_ext))
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

FILE: rtl/bol_ctrl.sv
module bol_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                      go,
    input  logic [bol_pkg::OP_W-1:0]  op,
    input  logic [bol_pkg::POS_W-1:0] pos,
    input  logic [bol_pkg::CNT_W-1:0] count,
    input  logic [bol_pkg::CNT_W-1:0] cap,
    output bol_pkg::cell_ctrl_t       ctrl,
    output bol_pkg::res_info_t        res
);
    import bol_pkg::*;

    localparam int               CAP_MAX   = (DEPTH < 63) ? DEPTH : 63;
    localparam logic [CNT_W-1:0] CAP_MAX_V = CNT_W'(CAP_MAX);

    logic [CNT_W-1:0] cap_eff;
    logic [POS_W-1:0] ins_pos;

    // A limit of zero acts as one; a limit above the smaller of the depth and 63 acts as that bound.
    always_comb
    begin
        if (cap == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap > CAP_MAX_V)
        begin
            cap_eff = CAP_MAX_V;
        end
        else
        begin
            cap_eff = cap;
        end
    end

    assign ins_pos = (op_t'(op) == OP_APPEND) ? count : pos;

    // Operation decode: status, new count and shift commands.
    always_comb
    begin
        ctrl       = '0;
        ctrl.pos   = pos;
        res.status = ST_OK;
        res.rd_ok  = 1'b0;
        res.count  = count;
        unique case (op_t'(op))
            OP_INSERT, OP_APPEND:
            begin
                if (ins_pos > count)
                begin
                    res.status = ST_INVALID;
                end
                else if (count >= cap_eff)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    ctrl.ins  = go;
                    ctrl.pos  = ins_pos;
                    res.count = count + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if ((pos > count) || ((pos == count) && (pos != '0)))
                begin
                    res.status = ST_INVALID;
                end
                else if (count == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    ctrl.rem  = go;
                    res.count = count - CNT_W'(1);
                end
            end
            OP_REMOVE_LAST:
            begin
                if (count == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    ctrl.rem  = go;
                    ctrl.pos  = count - CNT_W'(1);
                    res.count = count - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (pos >= count)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    res.rd_ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                ctrl.clr  = go;
                res.count = '0;
            end
            default:
            begin
                res.status = ST_INVALID;
            end
        endcase
        res.full  = (res.count >= cap_eff);
        res.empty = (res.count == '0);
    end

endmodule

FILE: rtl/bounded_ordered_list.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   op, position, move record fields
// result    out        out_valid / out_ready status, read record, entry_count, flags
// config    in         cfg_we                cfg_wdata (capacity limit)
//
// The row of cells shifts the list in the accepting cycle, and the result
// appears in the output register next cycle.
// A new transaction is taken while the output register is empty or being drained.
// Reset empties the list, zeroes every cell and sets the capacity limit to 32.
// A stalled result holds the input side until it is taken.
module bounded_ordered_list #(
    parameter int DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bol_pkg::OP_W-1:0]    op,
    input  logic [bol_pkg::POS_W-1:0]   position,
    input  logic [7:0]                  from_row,
    input  logic [7:0]                  from_col,
    input  logic [3:0]                  moved_piece,
    input  logic [7:0]                  to_row,
    input  logic [7:0]                  to_col,
    input  logic [3:0]                  taken_piece,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [7:0]                  rd_from_row,
    output logic [7:0]                  rd_from_col,
    output logic [3:0]                  rd_moved_piece,
    output logic [7:0]                  rd_to_row,
    output logic [7:0]                  rd_to_col,
    output logic [3:0]                  rd_taken_piece,
    output logic [bol_pkg::CNT_W-1:0]   entry_count,
    output logic                        is_full,
    output logic                        is_empty,
    input  logic                        cfg_we,
    input  logic [bol_pkg::CNT_W-1:0]   cfg_wdata
);
    import bol_pkg::*;

    // Only the first 64 cells are reachable by a read position.
    localparam int RD_N = (DEPTH < 64) ? DEPTH : 64;

    logic             accept;
    cell_ctrl_t       ctrl;
    res_info_t        res;
    rec_t             new_rec;
    rec_t             cell_q [DEPTH];
    rec_t             rd_mux;
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] cap_reg;
    logic             out_valid_reg;
    res_info_t        res_reg;
    rec_t             rd_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign new_rec = '{from_row: from_row, from_col: from_col, moved_piece: moved_piece,
                       to_row: to_row, to_col: to_col, taken_piece: taken_piece};

    bol_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .go    (accept),
        .op    (op),
        .pos   (position),
        .count (fill_count_reg),
        .cap   (cap_reg),
        .ctrl  (ctrl),
        .res   (res)
    );

    // Row of cells; each one talks to its neighbors, and the end cells see zero beyond the row.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        rec_t left_rec;
        rec_t right_rec;
        if (i == 0)
        begin : g_first
            assign left_rec = '0;
        end
        else
        begin : g_mid_left
            assign left_rec = cell_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_rec = '0;
        end
        else
        begin : g_mid_right
            assign right_rec = cell_q[i+1];
        end
        bol_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .left    (left_rec),
            .right   (right_rec),
            .new_rec (new_rec),
            .q       (cell_q[i])
        );
    end

    // Read select over the reachable cells.
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (position == POS_W'(i))
            begin
                rd_mux = rd_mux | cell_q[i];
            end
        end
    end

    // Count and capacity registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            cap_reg        <= CNT_W'(32);
        end
        else
        begin
            if (accept)
            begin
                fill_count_reg <= res.count;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded once per transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
            rd_reg  <= res.rd_ok ? rd_mux : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = res_reg.status;
    assign rd_from_row    = rd_reg.from_row;
    assign rd_from_col    = rd_reg.from_col;
    assign rd_moved_piece = rd_reg.moved_piece;
    assign rd_to_row      = rd_reg.to_row;
    assign rd_to_col      = rd_reg.to_col;
    assign rd_taken_piece = rd_reg.taken_piece;
    assign entry_count    = res_reg.count;
    assign is_full        = res_reg.full;
    assign is_empty       = res_reg.empty;

endmodule

FILE: rtl/bol_checker.sv
`include "bounded_ordered_list_macros.svh"

module bol_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [1:0]                status,
    input logic [7:0]                rd_from_row,
    input logic [7:0]                rd_from_col,
    input logic [3:0]                rd_moved_piece,
    input logic [7:0]                rd_to_row,
    input logic [7:0]                rd_to_col,
    input logic [3:0]                rd_taken_piece,
    input logic [bol_pkg::CNT_W-1:0] entry_count,
    input logic                      is_full,
    input logic                      is_empty
);
    import bol_pkg::*;

    // While a result is valid, the empty flag agrees with the reported count.
    `BOL_ASSERT_NOW(a_empty_flag, out_valid, (is_empty == (entry_count == '0)))

    // A full or empty status must come with the matching flag.
    `BOL_ASSERT_NOW(a_full_status, out_valid && (status == ST_FULL), is_full)
    `BOL_ASSERT_NOW(a_empty_status, out_valid && (status == ST_EMPTY), is_empty)

    // Only a successful transaction may carry a record; a failed one reads as zero.
    `BOL_ASSERT_NOW(a_rd_zero, out_valid && (status != ST_OK),
        (rd_from_row == 8'd0) && (rd_from_col == 8'd0) && (rd_moved_piece == 4'd0)
        && (rd_to_row == 8'd0) && (rd_to_col == 8'd0) && (rd_taken_piece == 4'd0))

    // A stalled result keeps its status and count.
    `BOL_ASSERT_NEXT(a_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(entry_count))

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .rd_from_row    (rd_from_row),
    .rd_from_col    (rd_from_col),
    .rd_moved_piece (rd_moved_piece),
    .rd_to_row      (rd_to_row),
    .rd_to_col      (rd_to_col),
    .rd_taken_piece (rd_taken_piece),
    .entry_count    (entry_count),
    .is_full        (is_full),
    .is_empty       (is_empty)
);
